[rtl/core/u8sv_pkg.sv]
package u8sv_pkg;

  // Upper bound on the per-buffer scalar count, held to the 16-bit field.
  localparam longint unsigned MaxCount = 64'd65535;
  localparam logic [15:0] CountLimit =
    (MaxCount > 64'd65535) ? 16'hFFFF : 16'(MaxCount);

  // Smallest scalar allowed for each sequence length, and the legal ceiling.
  localparam logic [20:0] MinTwoByte   = 21'h00080;
  localparam logic [20:0] MinThreeByte = 21'h00800;
  localparam logic [20:0] MinFourByte  = 21'h10000;
  localparam logic [20:0] MaxScalar    = 21'h10FFFF;
  localparam logic [20:0] SurrogateLo  = 21'h0D800;
  localparam logic [20:0] SurrogateHi  = 21'h0DFFF;

  // First-error codes reported on every result.
  typedef enum logic [2:0] {
    ErrNone     = 3'd0,
    ErrNul      = 3'd1,
    ErrLead     = 3'd2,
    ErrCont     = 3'd3,
    ErrOverlong = 3'd4,
    ErrRange    = 3'd5,
    ErrTrunc    = 3'd6
  } err_e;

  // Decoder state carried from byte to byte within one buffer.
  typedef struct packed {
    logic [1:0]  bytes_remaining;
    logic [2:0]  sequence_length;
    logic [20:0] partial_scalar;
    logic        failed;
    err_e        first_error;
    logic [15:0] count_so_far;
  } state_t;

  // One input item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  // One result item.
  typedef struct packed {
    logic        scalar_valid;
    logic [20:0] scalar_value;
    logic        buffer_done;
    logic        buffer_ok;
    err_e        error_kind;
    logic [15:0] scalar_count;
  } out_t;

endpackage

[rtl/core/u8sv_if.sv]
// Byte channel into the validator.
interface u8sv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result channel out of the validator.
interface u8sv_out_if;
  logic        valid;
  logic        ready;
  logic        scalar_valid;
  logic [20:0] scalar_value;
  logic        buffer_done;
  logic        buffer_ok;
  logic [2:0]  error_kind;
  logic [15:0] scalar_count;

  modport source (output valid, output scalar_valid, output scalar_value,
                  output buffer_done, output buffer_ok, output error_kind,
                  output scalar_count, input ready);
  modport sink   (input valid, input scalar_valid, input scalar_value,
                  input buffer_done, input buffer_ok, input error_kind,
                  input scalar_count, output ready);
endinterface

[rtl/core/u8sv_decode.sv]
module u8sv_decode (
  input  u8sv_pkg::state_t cur_i,
  input  u8sv_pkg::in_t    item_i,
  output u8sv_pkg::state_t nxt_o,
  output u8sv_pkg::out_t   res_o
);

  // Record an error (only the first one sticks) and drop any open sequence.
  function automatic u8sv_pkg::state_t set_err(u8sv_pkg::state_t s, u8sv_pkg::err_e code);
    u8sv_pkg::state_t r;
    r = s;
    if (!s.failed) begin
      r.failed      = 1'b1;
      r.first_error = code;
    end
    r.bytes_remaining = 2'd0;
    r.sequence_length = 3'd0;
    r.partial_scalar  = 21'd0;
    return r;
  endfunction

  // Minimum scalar for a sequence of the given length.
  function automatic logic [20:0] lowest_legal(logic [2:0] len);
    logic [20:0] m;
    case (len)
      3'd2:    m = u8sv_pkg::MinTwoByte;
      3'd3:    m = u8sv_pkg::MinThreeByte;
      3'd4:    m = u8sv_pkg::MinFourByte;
      default: m = 21'd0;
    endcase
    return m;
  endfunction

  logic [7:0]  b;
  logic [20:0] acc;
  logic        scl_valid;
  logic [20:0] scl_value;
  u8sv_pkg::state_t st;

  assign b   = item_i.data_byte;
  assign acc = {cur_i.partial_scalar[14:0], b[5:0]};

  // Classify the byte against the current state and advance it.
  always_comb begin
    st        = cur_i;
    scl_valid = 1'b0;
    scl_value = 21'd0;
    if (!cur_i.failed) begin
      if (cur_i.bytes_remaining == 2'd0) begin
        if (b == 8'h00) begin
          st = set_err(st, u8sv_pkg::ErrNul);
        end else if (!b[7]) begin
          scl_valid = 1'b1;
          scl_value = {13'd0, b};
        end else if (b[7:5] == 3'b110) begin
          st.sequence_length = 3'd2;
          st.bytes_remaining = 2'd1;
          st.partial_scalar  = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
          st.sequence_length = 3'd3;
          st.bytes_remaining = 2'd2;
          st.partial_scalar  = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
          st.sequence_length = 3'd4;
          st.bytes_remaining = 2'd3;
          st.partial_scalar  = {18'd0, b[2:0]};
        end else begin
          st = set_err(st, u8sv_pkg::ErrLead);
        end
      end else if (b[7:6] != 2'b10) begin
        st = set_err(st, u8sv_pkg::ErrCont);
      end else begin
        st.partial_scalar  = acc;
        st.bytes_remaining = cur_i.bytes_remaining - 2'd1;
        if (cur_i.bytes_remaining == 2'd1) begin
          if (acc < lowest_legal(cur_i.sequence_length)) begin
            st = set_err(st, u8sv_pkg::ErrOverlong);
          end else if (acc > u8sv_pkg::MaxScalar ||
                       (acc >= u8sv_pkg::SurrogateLo && acc <= u8sv_pkg::SurrogateHi)) begin
            st = set_err(st, u8sv_pkg::ErrRange);
          end else begin
            scl_valid          = 1'b1;
            scl_value          = acc;
            st.sequence_length = 3'd0;
            st.partial_scalar  = 21'd0;
          end
        end
      end
      if (scl_valid && cur_i.count_so_far < u8sv_pkg::CountLimit) begin
        st.count_so_far = cur_i.count_so_far + 16'd1;
      end
    end
    // An open sequence at the end of the buffer is truncation.
    if (item_i.last_byte && !st.failed && st.bytes_remaining != 2'd0) begin
      st = set_err(st, u8sv_pkg::ErrTrunc);
    end
  end

  // Build the result, then clear all state at the buffer boundary.
  always_comb begin
    res_o.scalar_valid = scl_valid;
    res_o.scalar_value = scl_value;
    res_o.buffer_done  = item_i.last_byte;
    res_o.buffer_ok    = item_i.last_byte && !st.failed;
    res_o.error_kind   = st.first_error;
    res_o.scalar_count = st.count_so_far;
    nxt_o = item_i.last_byte ? '0 : st;
  end

endmodule

[rtl/core/utf8_strict_stream_validator.sv]
// Path: a byte is captured in the input register and decoded into the result
// register, where its result waits out any output stall.
// Throughput: one byte per cycle while the output is not stalled; decode and
// state update are combinational between the two registers.
// Reset: rst_ni is asynchronous, active low; it empties both registers and
// clears the decoder state to the start of a fresh buffer.
module utf8_strict_stream_validator (
  input  logic        clk_i,
  input  logic        rst_ni,
  u8sv_in_if.sink     in_i,
  u8sv_out_if.source  out_o
);

  logic             in_valid_q;
  u8sv_pkg::in_t    in_q;
  logic             out_valid_q;
  u8sv_pkg::out_t   out_q;
  u8sv_pkg::state_t state_q, state_d;
  u8sv_pkg::out_t   res;
  logic             advance;

  // The held byte moves on when the result register is free or being drained.
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  u8sv_decode u_decode (
    .cur_i  (state_q),
    .item_i (in_q),
    .nxt_o  (state_d),
    .res_o  (res)
  );

  // Control registers: stage occupancy and decoder state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q.data_byte <= in_i.data_byte;
      in_q.last_byte <= in_i.last_byte;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  // Drive the result channel.
  assign out_o.valid        = out_valid_q;
  assign out_o.scalar_valid = out_q.scalar_valid;
  assign out_o.scalar_value = out_q.scalar_value;
  assign out_o.buffer_done  = out_q.buffer_done;
  assign out_o.buffer_ok    = out_q.buffer_ok;
  assign out_o.error_kind   = 3'(out_q.error_kind);
  assign out_o.scalar_count = out_q.scalar_count;

`ifndef SYNTHESIS
  // A buffer reported as good never carries an error code.
  a_ok_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.buffer_ok |-> out_q.error_kind == u8sv_pkg::ErrNone)
    else $error("buffer_ok with a nonzero error code");

  // A decoded scalar is never NUL, a surrogate or beyond the code space.
  a_scalar_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.scalar_valid |->
      out_q.scalar_value != 21'd0 && out_q.scalar_value <= u8sv_pkg::MaxScalar &&
      (out_q.scalar_value < u8sv_pkg::SurrogateLo ||
       out_q.scalar_value > u8sv_pkg::SurrogateHi))
    else $error("illegal scalar reported");

  // Processing the last byte of a buffer leaves the decoder state cleared.
  a_state_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.last_byte |=> state_q == '0)
    else $error("state not cleared after last byte");

  // Input stalls only when both registers are full and the output is stalled.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> in_valid_q && out_valid_q && !out_o.ready)
    else $error("input stalled without a full pipeline");
`endif

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;

  // Cycles without any transfer on either channel before the run is abandoned.
  localparam int unsigned IdleLimit = 2000;
  // Bytes of random buffers to send after the directed part.
  localparam int unsigned RandomBytes = 1070;
  // Cycles to linger after the last result before the run ends.
  localparam int unsigned DrainCycles = 16;

  typedef enum logic [1:0] {
    StallNone,
    StallHalf,
    StallHeavy,
    StallPeriodic
  } stall_e;

  typedef struct {
    logic [7:0]     data_byte;
    logic           last_byte;
    bit             fixed;
    u8sv_pkg::out_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  u8sv_in_if  byte_ch ();
  u8sv_out_if res_ch ();

  utf8_strict_stream_validator u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (res_ch)
  );

  // Decoder state mirrored by the predictor.
  logic [1:0]     dec_left;
  logic [2:0]     dec_len;
  logic [20:0]    dec_acc;
  logic           dec_bad;
  u8sv_pkg::err_e dec_err;
  logic [15:0]    dec_count;

  // Results still owed by the block, oldest first.
  u8sv_pkg::out_t owed_results[$];
  dir_row_t       dir_rows[$];
  logic [7:0]     buf_q[$];

  // Expectation typed into the table for the byte currently offered.
  bit             next_fixed;
  u8sv_pkg::out_t next_want;

  int unsigned burst_left;
  int unsigned fail_count;
  int unsigned idle_cycles;
  int unsigned bytes_in;
  int unsigned buffers_seen;
  int unsigned scalars_seen;
  int unsigned err_hist [7];

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_decoder();
    dec_left  = '0;
    dec_len   = '0;
    dec_acc   = '0;
    dec_bad   = 1'b0;
    dec_err   = u8sv_pkg::ErrNone;
    dec_count = '0;
  endfunction

  // Only the first error of a buffer is kept; any partial sequence is dropped.
  function automatic void flag_error(u8sv_pkg::err_e code);
    if (!dec_bad) begin
      dec_bad = 1'b1;
      dec_err = code;
    end
    dec_left = '0;
    dec_len  = '0;
    dec_acc  = '0;
  endfunction

  // Works out the result for one byte and advances the mirrored decoder.
  function automatic u8sv_pkg::out_t predict_utf8(logic [7:0] b, logic last);
    u8sv_pkg::out_t r;
    logic [20:0]    floor_v;
    r = '0;
    if (!dec_bad) begin
      if (dec_left == 2'd0) begin
        if (b == 8'h00) begin
          flag_error(u8sv_pkg::ErrNul);
        end else if (b < 8'h80) begin
          r.scalar_valid = 1'b1;
          r.scalar_value = {13'd0, b};
        end else if (b[7:5] == 3'b110) begin
          dec_len  = 3'd2;
          dec_left = 2'd1;
          dec_acc  = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
          dec_len  = 3'd3;
          dec_left = 2'd2;
          dec_acc  = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
          dec_len  = 3'd4;
          dec_left = 2'd3;
          dec_acc  = {18'd0, b[2:0]};
        end else begin
          flag_error(u8sv_pkg::ErrLead);
        end
      end else if (b[7:6] != 2'b10) begin
        flag_error(u8sv_pkg::ErrCont);
      end else begin
        dec_acc  = {dec_acc[14:0], b[5:0]};
        dec_left = dec_left - 2'd1;
        if (dec_left == 2'd0) begin
          case (dec_len)
            3'd2:    floor_v = u8sv_pkg::MinTwoByte;
            3'd3:    floor_v = u8sv_pkg::MinThreeByte;
            default: floor_v = u8sv_pkg::MinFourByte;
          endcase
          if (dec_acc < floor_v) begin
            flag_error(u8sv_pkg::ErrOverlong);
          end else if (dec_acc > u8sv_pkg::MaxScalar ||
                       (dec_acc >= u8sv_pkg::SurrogateLo &&
                        dec_acc <= u8sv_pkg::SurrogateHi)) begin
            flag_error(u8sv_pkg::ErrRange);
          end else begin
            r.scalar_valid = 1'b1;
            r.scalar_value = dec_acc;
            dec_len = '0;
            dec_acc = '0;
          end
        end
      end
      if (r.scalar_valid && dec_count < u8sv_pkg::CountLimit) begin
        dec_count = dec_count + 16'd1;
      end
    end
    if (last && !dec_bad && dec_left != 2'd0) begin
      flag_error(u8sv_pkg::ErrTrunc);
    end
    r.buffer_done  = last;
    r.buffer_ok    = last && !dec_bad;
    r.error_kind   = dec_err;
    r.scalar_count = dec_count;
    if (last) begin
      clear_decoder();
    end
    return r;
  endfunction

  function automatic string fmt_res(u8sv_pkg::out_t r);
    return $sformatf("scalar_valid=%0b value=%06h done=%0b ok=%0b err=%0d count=%0d",
                     r.scalar_valid, r.scalar_value, r.buffer_done, r.buffer_ok,
                     r.error_kind, r.scalar_count);
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  // Result of a final byte, as typed into the directed table.
  function automatic u8sv_pkg::out_t done_res(logic sv, logic [20:0] val, logic ok,
                                              u8sv_pkg::err_e code, logic [15:0] cnt);
    u8sv_pkg::out_t r;
    r.scalar_valid = sv;
    r.scalar_value = val;
    r.buffer_done  = 1'b1;
    r.buffer_ok    = ok;
    r.error_kind   = code;
    r.scalar_count = cnt;
    return r;
  endfunction

  function automatic void add_row(logic [7:0] b, logic last);
    dir_row_t r;
    r.data_byte = b;
    r.last_byte = last;
    r.fixed     = 1'b0;
    r.want      = '0;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void add_fixed(logic [7:0] b, u8sv_pkg::out_t want);
    dir_row_t r;
    r.data_byte = b;
    r.last_byte = 1'b1;
    r.fixed     = 1'b1;
    r.want      = want;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // Appends one byte to the buffer under construction.
  function automatic void put_byte(logic [7:0] b);
    buf_q.insert(buf_q.size(), b);
  endfunction

  // Encodes a value into a sequence of the given length, legal or not.
  function automatic void append_enc(logic [20:0] s, int unsigned len);
    case (len)
      1: put_byte(s[7:0]);
      2: begin
        put_byte({3'b110, s[10:6]});
        put_byte({2'b10, s[5:0]});
      end
      3: begin
        put_byte({4'b1110, s[15:12]});
        put_byte({2'b10, s[11:6]});
        put_byte({2'b10, s[5:0]});
      end
      default: begin
        put_byte({5'b11110, s[20:18]});
        put_byte({2'b10, s[17:12]});
        put_byte({2'b10, s[11:6]});
        put_byte({2'b10, s[5:0]});
      end
    endcase
  endfunction

  // A legal scalar that naturally needs the given sequence length.
  function automatic logic [20:0] legal_scalar(int unsigned len);
    case (len)
      1: return 21'($urandom_range(1, 'h7F));
      2: return 21'($urandom_range('h80, 'h7FF));
      3: begin
        if ($urandom_range(0, 1) == 0) return 21'($urandom_range('h800, 'hD7FF));
        return 21'($urandom_range('hE000, 'hFFFF));
      end
      default: return 21'($urandom_range('h10000, 'h10FFFF));
    endcase
  endfunction

  // Builds one random buffer: mostly well-formed text, with some damage mixed in.
  function automatic void build_buffer();
    int unsigned n_chars;
    int unsigned pick;
    int unsigned len;
    int unsigned cut;
    logic [7:0]  junk;
    buf_q.delete();
    n_chars = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    for (int unsigned i = 0; i < n_chars; i++) begin
      pick = $urandom_range(0, 99);
      len  = $urandom_range(1, 4);
      if (pick < 75) begin
        append_enc(legal_scalar(len), len);
      end else if (pick < 78) begin
        put_byte(8'h00);
      end else if (pick < 81) begin
        put_byte(8'($urandom_range('h80, 'hBF)));
      end else if (pick < 83) begin
        put_byte(8'($urandom_range('hF8, 'hFF)));
      end else if (pick < 86) begin
        // Overlong: a value that fits a shorter form.
        len = $urandom_range(2, 4);
        case (len)
          2:       append_enc(21'($urandom_range(0, 'h7F)), 2);
          3:       append_enc(21'($urandom_range(0, 'h7FF)), 3);
          default: append_enc(21'($urandom_range(0, 'hFFFF)), 4);
        endcase
      end else if (pick < 89) begin
        append_enc(21'($urandom_range('hD800, 'hDFFF)), 3);
      end else if (pick < 92) begin
        append_enc(21'($urandom_range('h110000, 'h1FFFFF)), 4);
      end else if (pick < 96) begin
        // Lead byte followed by something that is not a continuation.
        len = $urandom_range(2, 4);
        append_enc(legal_scalar(len), len);
        cut = $urandom_range(1, len - 1);
        repeat (len - cut) void'(buf_q.pop_back());
        junk = 8'($urandom_range(0, 255));
        if (junk[7:6] == 2'b10) junk[6] = 1'b1;
        put_byte(junk);
      end else begin
        // Sequence cut short by the end of the buffer, if it is the last character.
        len = $urandom_range(2, 4);
        append_enc(legal_scalar(len), len);
        if (i == n_chars - 1) begin
          cut = $urandom_range(1, len - 1);
          repeat (cut) void'(buf_q.pop_back());
        end
      end
    end
  endfunction

  // Offers one byte, in bursts separated by random gaps, and waits for its transfer.
  task automatic send_byte(logic [7:0] b, logic last, bit fixed, u8sv_pkg::out_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk_i);
        byte_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= last;
    next_fixed = fixed;
    next_want  = want;
    do @(posedge clk_i); while (!byte_ch.ready);
  endtask

  // Result side backpressure: the stall pattern changes every so often.
  initial begin : result_stall
    stall_e      mode;
    int unsigned hold;
    int unsigned tick;
    res_ch.ready = 1'b0;
    mode = StallNone;
    hold = 0;
    tick = 0;
    forever begin
      @(negedge clk_i);
      if (hold == 0) begin
        mode = stall_e'($urandom_range(0, 3));
        hold = $urandom_range(16, 200);
      end
      hold--;
      tick++;
      case (mode)
        StallNone:  res_ch.ready <= 1'b1;
        StallHalf:  res_ch.ready <= 1'($urandom_range(0, 1));
        StallHeavy: res_ch.ready <= ($urandom_range(0, 3) == 0);
        default:    res_ch.ready <= tick[2];
      endcase
    end
  end

  // Predict on each byte transfer, check each result transfer, and watch for hangs.
  always @(posedge clk_i) begin : scoreboard
    u8sv_pkg::out_t want;
    u8sv_pkg::out_t got;
    bit             moved;
    moved = 1'b0;
    if (rst_ni && byte_ch.valid && byte_ch.ready) begin
      moved = 1'b1;
      want = predict_utf8(byte_ch.data_byte, byte_ch.last_byte);
      if (next_fixed) want = next_want;
      bytes_in++;
      if (want.scalar_valid) scalars_seen++;
      if (want.buffer_done) begin
        buffers_seen++;
        err_hist[want.error_kind]++;
      end
      owed_results.insert(owed_results.size(), want);
    end
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      moved = 1'b1;
      got.scalar_valid = res_ch.scalar_valid;
      got.scalar_value = res_ch.scalar_value;
      got.buffer_done  = res_ch.buffer_done;
      got.buffer_ok    = res_ch.buffer_ok;
      got.error_kind   = u8sv_pkg::err_e'(res_ch.error_kind);
      got.scalar_count = res_ch.scalar_count;
      if (owed_results.size() == 0) begin
        note_failure({"result with nothing pending: ", fmt_res(got)});
      end else begin
        want = owed_results.pop_front();
        if (got.scalar_valid !== want.scalar_valid ||
            got.scalar_value !== want.scalar_value ||
            got.buffer_done  !== want.buffer_done  ||
            got.buffer_ok    !== want.buffer_ok    ||
            got.error_kind   !== want.error_kind   ||
            got.scalar_count !== want.scalar_count) begin
          note_failure({"mismatch\n  expected ", fmt_res(want), "\n  actual   ", fmt_res(got)});
        end
      end
    end
    if (rst_ni) begin
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("[%0t] no transfer for %0d cycles, %0d results pending",
                 $realtime, IdleLimit, owed_results.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Stimulus: directed table first, then random buffers.
  initial begin : stimulus
    int unsigned rand_bytes;
    rst_ni            = 1'b0;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = 8'h00;
    byte_ch.last_byte = 1'b0;
    next_fixed        = 1'b0;
    next_want         = '0;
    burst_left        = 0;
    fail_count        = 0;
    idle_cycles       = 0;
    bytes_in          = 0;
    buffers_seen      = 0;
    scalars_seen      = 0;
    rand_bytes        = 0;
    foreach (err_hist[i]) err_hist[i] = 0;
    clear_decoder();

    // Single ASCII character, then a lone NUL.
    add_fixed(8'h41, done_res(1'b1, 21'h41, 1'b1, u8sv_pkg::ErrNone, 16'd1));
    add_fixed(8'h00, done_res(1'b0, '0, 1'b0, u8sv_pkg::ErrNul, 16'd0));
    // Highest ASCII byte, then FF as a lead.
    add_row(8'h7F, 1'b0);
    add_fixed(8'hFF, done_res(1'b0, '0, 1'b0, u8sv_pkg::ErrLead, 16'd1));
    // Stray continuation byte.
    add_fixed(8'h80, done_res(1'b0, '0, 1'b0, u8sv_pkg::ErrLead, 16'd0));
    // Two-byte encoding of zero.
    add_row(8'hC0, 1'b0);
    add_fixed(8'h80, done_res(1'b0, '0, 1'b0, u8sv_pkg::ErrOverlong, 16'd0));
    // Smallest legal two-byte scalar, then an overlong three-byte form.
    add_row(8'hC2, 1'b0);
    add_row(8'h80, 1'b0);
    add_row(8'hE0, 1'b0);
    add_row(8'h9F, 1'b0);
    add_fixed(8'hBF, done_res(1'b0, '0, 1'b0, u8sv_pkg::ErrOverlong, 16'd1));
    // First surrogate.
    add_row(8'hED, 1'b0);
    add_row(8'hA0, 1'b0);
    add_fixed(8'h80, done_res(1'b0, '0, 1'b0, u8sv_pkg::ErrRange, 16'd0));
    // Highest legal scalar.
    add_row(8'hF4, 1'b0);
    add_row(8'h8F, 1'b0);
    add_row(8'hBF, 1'b0);
    add_fixed(8'hBF, done_res(1'b1, u8sv_pkg::MaxScalar, 1'b1, u8sv_pkg::ErrNone, 16'd1));
    // Overlong four-byte form, then a byte that must be ignored.
    add_row(8'hF0, 1'b0);
    add_row(8'h8F, 1'b0);
    add_row(8'hBF, 1'b0);
    add_row(8'hBF, 1'b0);
    add_fixed(8'h41, done_res(1'b0, '0, 1'b0, u8sv_pkg::ErrOverlong, 16'd0));
    // Buffer ends inside a sequence.
    add_fixed(8'hE2, done_res(1'b0, '0, 1'b0, u8sv_pkg::ErrTrunc, 16'd0));
    // Lead followed by an ASCII byte.
    add_row(8'hC3, 1'b0);
    add_fixed(8'h28, done_res(1'b0, '0, 1'b0, u8sv_pkg::ErrCont, 16'd0));

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].data_byte, dir_rows[i].last_byte, dir_rows[i].fixed,
                dir_rows[i].want);
    end

    while (rand_bytes < RandomBytes) begin
      build_buffer();
      foreach (buf_q[i]) send_byte(buf_q[i], i == buf_q.size() - 1, 1'b0, '0);
      rand_bytes += buf_q.size();
    end

    @(negedge clk_i);
    byte_ch.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (owed_results.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", owed_results.size()));
    end

    $display("Checked %0d bytes in %0d buffers, %0d scalars decoded, %0d failures.",
             bytes_in, buffers_seen, scalars_seen, fail_count);
    $display({"Buffer outcomes: ok %0d, nul %0d, lead %0d, cont %0d, ",
              "overlong %0d, range %0d, trunc %0d"},
             err_hist[u8sv_pkg::ErrNone], err_hist[u8sv_pkg::ErrNul],
             err_hist[u8sv_pkg::ErrLead], err_hist[u8sv_pkg::ErrCont],
             err_hist[u8sv_pkg::ErrOverlong], err_hist[u8sv_pkg::ErrRange],
             err_hist[u8sv_pkg::ErrTrunc]);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/u8sv_pkg.sv
rtl/core/u8sv_if.sv
rtl/core/u8sv_decode.sv
rtl/core/utf8_strict_stream_validator.sv
bench/tb.sv
